>>> hw/rtl/gda_pkg.sv
// Package for the greyscale dilation argmax unit: sizes, op codes, command types.
// No dependencies.
`timescale 1ns / 1ps
package gda_pkg;
    localparam int MAX_HEIGHT        = 64;
    localparam int MAX_WIDTH         = 64;
    localparam int MAX_IN_CHANNELS   = 4;
    localparam int MAX_OUT_CHANNELS  = 4;
    localparam int MAX_KERNEL_HEIGHT = 8;
    localparam int MAX_KERNEL_WIDTH  = 8;

    localparam logic [1:0] OP_WR_PIXEL  = 2'd0;
    localparam logic [1:0] OP_WR_WEIGHT = 2'd1;
    localparam logic [1:0] OP_QUERY     = 2'd2;

    localparam logic [2:0] REG_HEIGHT  = 3'd0;
    localparam logic [2:0] REG_WIDTH   = 3'd1;
    localparam logic [2:0] REG_CHAN    = 3'd2;
    localparam logic [2:0] REG_KHEIGHT = 3'd3;
    localparam logic [2:0] REG_KWIDTH  = 3'd4;
    localparam logic [2:0] REG_ORG_ROW = 3'd5;
    localparam logic [2:0] REG_ORG_COL = 3'd6;
    localparam logic [2:0] REG_PAD     = 3'd7;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture input beat, start query
        logic step;   // issue one kernel tap read
        logic last;   // this tap is the final one
        logic finish; // latch result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_query;  // captured beat is an in-range or out-of-range query
        logic err;       // query out of range or no taps to visit: no walk
        logic walk_done; // all tap counters are at their last tap
        logic drain;     // pipeline has emptied
    } t_status;
endpackage

>>> hw/rtl/gda_ctrl.sv
// Controller FSM for the dilation unit: sequences capture, tap walk, result.
// Depends on gda_pkg.
`timescale 1ns / 1ps
module gda_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_fire,
    input  logic             i_out_free,
    input  gda_pkg::t_status i_status,
    output gda_pkg::t_cmd    o_cmd,
    output logic             o_in_ready
);
    import gda_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state, n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (!i_status.is_query) n_state = S_IDLE;
                else if (i_status.err)  n_state = S_OUT;
                else                    n_state = S_WALK;
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                o_cmd.last = i_status.walk_done;
                if (i_status.walk_done) n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_status.drain) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule

>>> hw/rtl/gda_dp.sv
// Datapath for the dilation unit: config registers, stores, tap walk, max search.
// Depends on gda_pkg.
`timescale 1ns / 1ps
module gda_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [16:0]      i_cfg_data,
    input  logic [1:0]       i_operation,
    input  logic [1:0]       i_channel_in,
    input  logic [1:0]       i_channel_out,
    input  logic [5:0]       i_row,
    input  logic [5:0]       i_col,
    input  logic [2:0]       i_kernel_row,
    input  logic [2:0]       i_kernel_col,
    input  logic [15:0]      i_value,
    input  gda_pkg::t_cmd    i_cmd,
    output gda_pkg::t_status o_status,
    output logic             o_res_valid,
    input  logic             i_res_take,
    output logic [16:0]      o_result_value,
    output logic             o_found,
    output logic [7:0]       o_best_index,
    output logic             o_range_error
);
    import gda_pkg::*;

    // config registers
    logic [6:0]  r_height, r_width;
    logic [2:0]  r_chan, r_org_row, r_org_col;
    logic [3:0]  r_kh, r_kw;
    logic [16:0] r_pad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height  <= 7'd64;
            r_width   <= 7'd64;
            r_chan    <= 3'd1;
            r_kh      <= 4'd3;
            r_kw      <= 4'd3;
            r_org_row <= 3'd1;
            r_org_col <= 3'd1;
            r_pad     <= 17'h10000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_HEIGHT:  r_height  <= i_cfg_data[6:0];
                REG_WIDTH:   r_width   <= i_cfg_data[6:0];
                REG_CHAN:    r_chan    <= i_cfg_data[2:0];
                REG_KHEIGHT: r_kh      <= i_cfg_data[3:0];
                REG_KWIDTH:  r_kw      <= i_cfg_data[3:0];
                REG_ORG_ROW: r_org_row <= i_cfg_data[2:0];
                REG_ORG_COL: r_org_col <= i_cfg_data[2:0];
                REG_PAD:     r_pad     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective sizes, clamped to maxima
    logic [6:0] w_h, w_w;
    logic [2:0] w_c;
    logic [3:0] w_kh, w_kw;
    assign w_h  = (r_height > 7'd64) ? 7'd64 : r_height;
    assign w_w  = (r_width  > 7'd64) ? 7'd64 : r_width;
    assign w_c  = (r_chan   > 3'd4)  ? 3'd4  : r_chan;
    assign w_kh = (r_kh     > 4'd8)  ? 4'd8  : r_kh;
    assign w_kw = (r_kw     > 4'd8)  ? 4'd8  : r_kw;

    // captured beat
    logic [1:0]  r_op, r_co;
    logic [5:0]  r_row, r_col;
    logic        r_err;

    logic w_pix_ok, w_wt_ok, w_q_err;
    assign w_pix_ok = ({1'b0, i_channel_in} < w_c) && ({1'b0, i_row} < w_h)
                   && ({1'b0, i_col} < w_w);
    assign w_wt_ok  = ({1'b0, i_channel_in} < w_c) && ({1'b0, i_kernel_row} < w_kh)
                   && ({1'b0, i_kernel_col} < w_kw);
    assign w_q_err  = !(({1'b0, i_row} < w_h) && ({1'b0, i_col} < w_w));

    // stores
    logic [15:0] r_pix_mem [MAX_IN_CHANNELS*MAX_HEIGHT*MAX_WIDTH];
    logic [15:0] r_wt_mem  [MAX_OUT_CHANNELS*MAX_IN_CHANNELS*MAX_KERNEL_HEIGHT*MAX_KERNEL_WIDTH];
    logic [15:0] r_pix_q, r_wt_q;

    // tap counters
    logic [1:0] r_ci;
    logic [2:0] r_khc, r_kwc;
    logic       w_kw_end, w_kh_end, w_ci_end;
    assign w_kw_end = ({1'b0, r_kwc} == w_kw - 4'd1);
    assign w_kh_end = ({1'b0, r_khc} == w_kh - 4'd1);
    assign w_ci_end = ({1'b0, r_ci} == w_c - 3'd1);

    // pixel position of the current tap
    logic signed [8:0] w_hi, w_wi;
    logic              w_in_img;
    assign w_hi = $signed({3'b0, r_row}) + $signed({6'b0, r_org_row})
                - $signed({6'b0, r_khc});
    assign w_wi = $signed({3'b0, r_col}) + $signed({6'b0, r_org_col})
                - $signed({6'b0, r_kwc});
    assign w_in_img = (w_hi >= 0) && (w_hi < $signed({2'b0, w_h}))
                   && (w_wi >= 0) && (w_wi < $signed({2'b0, w_w}));

    // write ports and tap reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_operation == OP_WR_PIXEL && w_pix_ok)
            r_pix_mem[{i_channel_in, i_row, i_col}] <= i_value;
        if (i_cmd.load && i_operation == OP_WR_WEIGHT && w_wt_ok)
            r_wt_mem[{i_channel_out, i_channel_in, i_kernel_row, i_kernel_col}] <= i_value;
        r_pix_q <= r_pix_mem[{r_ci, w_hi[5:0], w_wi[5:0]}];
        r_wt_q  <= r_wt_mem[{r_co, r_ci, r_khc, r_kwc}];
    end

    // flat index of current tap: ci*KH*KW + kh*KW + kw, built incrementally
    logic [7:0] r_flat;

    // stage 1 tag: valid, index
    logic       r_s1_vld;
    logic [7:0] r_s1_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.step && w_in_img;
        end
        r_s1_idx <= r_flat;
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_co  <= i_channel_out;
            r_row <= i_row;
            r_col <= i_col;
            r_err <= w_q_err;
            r_ci  <= '0;
            r_khc <= '0;
            r_kwc <= '0;
            r_flat <= '0;
        end else if (i_cmd.step) begin
            r_flat <= r_flat + 8'd1;
            if (w_kw_end) begin
                r_kwc <= '0;
                if (w_kh_end) begin
                    r_khc <= '0;
                    r_ci  <= r_ci + 2'd1;
                end else begin
                    r_khc <= r_khc + 3'd1;
                end
            end else begin
                r_kwc <= r_kwc + 3'd1;
            end
        end
    end

    // running max
    logic signed [16:0] r_best, w_sum;
    logic               r_found;
    logic [7:0]         r_bidx;
    logic               r_s1_last, r_draining;
    assign w_sum = $signed({r_pix_q[15], r_pix_q}) + $signed({r_wt_q[15], r_wt_q});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draining <= 1'b0;
            r_s1_last  <= 1'b0;
        end else begin
            r_s1_last  <= i_cmd.step && i_cmd.last;
            r_draining <= r_s1_last;
        end
        if (i_cmd.load) begin
            r_best  <= $signed(r_pad);
            r_found <= 1'b0;
            r_bidx  <= '0;
        end else if (r_s1_vld && w_sum > r_best) begin
            r_best  <= w_sum;
            r_found <= 1'b1;
            r_bidx  <= r_s1_idx;
        end
    end

    // a zero channel or kernel size leaves no taps: answer with the padding at once
    assign o_status.is_query  = (r_op == OP_QUERY);
    assign o_status.err       = r_err || (w_c == 3'd0) || (w_kh == 4'd0) || (w_kw == 4'd0);
    assign o_status.walk_done = w_kw_end && w_kh_end && w_ci_end;
    assign o_status.drain     = r_draining;

    // output register
    logic r_res_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_res_vld <= 1'b1;
        end else if (i_res_take) begin
            r_res_vld <= 1'b0;
        end
        if (i_cmd.finish) begin
            o_result_value <= r_err ? r_pad : r_best;
            o_found        <= r_err ? 1'b0 : r_found;
            o_best_index   <= r_err ? 8'd0 : r_bidx;
            o_range_error  <= r_err;
        end
    end
    assign o_res_valid = r_res_vld;
endmodule

>>> hw/rtl/greyscale_dilation_argmax_unit.sv
// Sequence: a write beat is captured and decoded; an in-range query then walks its
// C*KH*KW taps, one tap read per cycle from the stores, lets the pipeline drain, and
// shows its result; an out-of-range query, or one with no taps, skips the walk.
// Throughput: one beat at a time; after a query the next beat is taken the cycle after
// the result register loads, later while a result waits; after a write, once decoded.
// Reset (synchronous, active low) restores register defaults; stores stay undefined.
`timescale 1ns / 1ps
module greyscale_dilation_argmax_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[1:0], channel_in[3:2], channel_out[5:4], row[11:6], col[17:12],
    // kernel_row[20:18], kernel_col[23:21], value[39:24]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_value[16:0], found[17], best_index[25:18], range_error[26]
    output logic [31:0] m_axis_tdata
);
    import gda_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic [16:0] w_val;
    logic        w_found, w_err;
    logic [7:0]  w_idx;

    gda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (s_axis_tvalid && s_axis_tready),
        .i_out_free (!m_axis_tvalid || m_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_ready (s_axis_tready)
    );

    gda_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_operation    (s_axis_tdata[1:0]),
        .i_channel_in   (s_axis_tdata[3:2]),
        .i_channel_out  (s_axis_tdata[5:4]),
        .i_row          (s_axis_tdata[11:6]),
        .i_col          (s_axis_tdata[17:12]),
        .i_kernel_row   (s_axis_tdata[20:18]),
        .i_kernel_col   (s_axis_tdata[23:21]),
        .i_value        (s_axis_tdata[39:24]),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_res_valid    (m_axis_tvalid),
        .i_res_take     (m_axis_tready),
        .o_result_value (w_val),
        .o_found        (w_found),
        .o_best_index   (w_idx),
        .o_range_error  (w_err)
    );

    assign m_axis_tdata = {5'd0, w_err, w_idx, w_found, w_val};
endmodule
